/* sv/fds_pkg.sv */
package fds_pkg;

    localparam int DUR_W          = 16;
    localparam int CNT_W          = 8;
    localparam int ACC_W          = DUR_W + CNT_W;
    localparam int SAMPLE_CAP_DEF = 128;

    // bit-serial schedule: one multiplier bit, then one quotient bit per cycle
    localparam int MUL_STEPS = CNT_W;
    localparam int DIV_STEPS = ACC_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    // divisor of the three-sample mean
    localparam int          DIV3_W = 2;
    localparam logic [1:0]  DIV3   = 2'd3;

    localparam int IN_TDATA_W  = ((DUR_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * DUR_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        FDS_IDLE,
        FDS_MUL,
        FDS_LOAD,
        FDS_DIV,
        FDS_DONE
    } fds_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } fds_div_ctrl_t;

endpackage

/* sv/fds_serial_div.sv */
module fds_serial_div #(
    parameter int NUM_W = fds_pkg::ACC_W,
    parameter int DEN_W = fds_pkg::CNT_W
) (
    input  logic                  aclk,
    input  fds_pkg::fds_div_ctrl_t ctrl,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output logic [NUM_W-1:0]      quotient
);
    import fds_pkg::*;

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // restoring division, numerator shifts out at the top, quotient enters at the bottom
    always_comb begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (ctrl.load) begin
            quo_next = num;
            rem_next = '0;
        end else if (ctrl.step) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (ctrl.load) begin
            den_reg <= den;
        end
    end

    assign quotient = quo_reg;

endmodule

/* sv/frame_duration_statistics.sv */
// frame duration statistics
// input channel s_axis: one 16-bit duration sample per transaction
// result channel m_axis: one result per input transaction holding the
// cumulative average, the mean of the last three samples (the newest if
// any is zero), the running minimum and the number of samples in the
// average, all after the update; a sample is accepted, the bit-serial
// average*count product is formed, the two bit-serial restoring dividers
// are loaded and run side by side over the 24-bit quotient, the longest
// step, and the result commits; only then is a new sample accepted
// s_axis_tready is high only while the datapath is idle; a finished result
// sits in an output register, so the next sample is taken even while the
// receiver stalls, and the datapath then waits to commit its own result
// until that register is free
// reset (aresetn low, synchronous): count and average go to zero, the
// minimum to 65535, the delay line to zero and any pending result is dropped
module frame_duration_statistics #(
    parameter int SAMPLE_CAP = fds_pkg::SAMPLE_CAP_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fds_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [15:0] duration
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [15:0] average, [31:16] recent_average, [47:32] minimum, [55:48] count
    output logic [fds_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import fds_pkg::*;

    fds_state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    fds_div_ctrl_t     div_ctrl;
    logic              s_accept;
    logic              commit;

    // running statistics
    logic [CNT_W-1:0] count_reg;
    logic [DUR_W-1:0] avg_reg;
    logic [DUR_W-1:0] min_reg;
    logic [DUR_W-1:0] oldest_reg, middle_reg, newest_reg;
    logic             update_reg;   // count still below the cap for this sample

    // serial product average*count
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] mcand_reg;

    // divider operands and results
    logic [ACC_W-1:0] total;
    logic [CNT_W-1:0] den_avg;
    logic [ACC_W-1:0] sum3;
    logic [ACC_W-1:0] q_avg, q_recent;
    logic             all_nonzero;

    // output register
    logic             out_valid_reg;
    logic [DUR_W-1:0] out_avg_reg, out_recent_reg, out_min_reg;
    logic [CNT_W-1:0] out_count_reg;

    assign s_axis_tready = (state_reg == FDS_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // sequencer: next state, step counter and divider control
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        div_ctrl      = '0;
        commit        = 1'b0;
        case (state_reg)
            FDS_IDLE: begin
                if (s_accept) begin
                    state_next = FDS_MUL;
                    step_next  = '0;
                end
            end
            FDS_MUL: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MUL_STEPS - 1)) begin
                    state_next = FDS_LOAD;
                end
            end
            FDS_LOAD: begin
                div_ctrl.load = 1'b1;
                step_next     = '0;
                state_next    = FDS_DIV;
            end
            FDS_DIV: begin
                div_ctrl.step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = FDS_DONE;
                end
            end
            FDS_DONE: begin
                // wait for the output register to be free
                if (!out_valid_reg || m_axis_tready) begin
                    commit     = 1'b1;
                    state_next = FDS_IDLE;
                end
            end
            default: begin
                state_next = FDS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FDS_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // one multiplier bit per cycle, count msb first
    always_comb begin
        acc_next = acc_reg;
        if (s_accept) begin
            acc_next = '0;
        end else if (state_reg == FDS_MUL) begin
            acc_next = {acc_reg[ACC_W-2:0], 1'b0}
                     + (mcand_reg[CNT_W-1] ? ACC_W'(avg_reg) : '0);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (s_accept) begin
            mcand_reg <= count_reg;
        end else if (state_reg == FDS_MUL) begin
            mcand_reg <= {mcand_reg[CNT_W-2:0], 1'b0};
        end
    end

    assign total       = acc_reg + ACC_W'(newest_reg);
    assign den_avg     = count_reg + 1'b1;
    assign sum3        = ACC_W'(oldest_reg) + ACC_W'(middle_reg) + ACC_W'(newest_reg);
    assign all_nonzero = (oldest_reg != '0) && (middle_reg != '0) && (newest_reg != '0);

    fds_serial_div #(
        .NUM_W (ACC_W),
        .DEN_W (CNT_W)
    ) u_div_avg (
        .aclk     (aclk),
        .ctrl     (div_ctrl),
        .num      (total),
        .den      (den_avg),
        .quotient (q_avg)
    );

    fds_serial_div #(
        .NUM_W (ACC_W),
        .DEN_W (DIV3_W)
    ) u_div_recent (
        .aclk     (aclk),
        .ctrl     (div_ctrl),
        .num      (sum3),
        .den      (DIV3),
        .quotient (q_recent)
    );

    // statistics state: delay line and minimum move at the transaction,
    // average and count when the result commits, and only below the cap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            avg_reg    <= '0;
            min_reg    <= '1;
            oldest_reg <= '0;
            middle_reg <= '0;
            newest_reg <= '0;
            update_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                oldest_reg <= middle_reg;
                middle_reg <= newest_reg;
                newest_reg <= s_axis_tdata[DUR_W-1:0];
                update_reg <= (count_reg < CNT_W'(SAMPLE_CAP));
                if (min_reg == '0 || s_axis_tdata[DUR_W-1:0] < min_reg) begin
                    min_reg <= s_axis_tdata[DUR_W-1:0];
                end
            end
            if (commit && update_reg) begin
                count_reg <= den_avg;
                avg_reg   <= q_avg[DUR_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_avg_reg    <= update_reg ? q_avg[DUR_W-1:0] : avg_reg;
            out_count_reg  <= update_reg ? den_avg : count_reg;
            out_recent_reg <= all_nonzero ? q_recent[DUR_W-1:0] : newest_reg;
            out_min_reg    <= min_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_count_reg, out_min_reg,
                                         out_recent_reg, out_avg_reg});

endmodule

/* sv/fds_checker.sv */
module fds_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [fds_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [fds_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import fds_pkg::*;

    logic [DUR_W-1:0] in_duration;
    logic [CNT_W-1:0] out_count;

    assign in_duration = s_axis_tdata[DUR_W-1:0];
    assign out_count   = m_axis_tdata[3*DUR_W +: CNT_W];

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // no result and an idle input side right after reset
    assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> !m_axis_tvalid && s_axis_tready)
        else $error("state after reset wrong");

    // the serial datapath stays busy after taking a sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("sample accepted while busy");

    // every result counts at least the first sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> out_count != '0)
        else $error("result with zero count");

    // a sample of zero that is accepted into an idle block never shows as a
    // result in the very next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid && in_duration == '0
        |=> !m_axis_tvalid)
        else $error("result appeared too early");

endmodule

bind frame_duration_statistics fds_checker u_fds_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/frame_duration_statistics_tb.sv */
module frame_duration_statistics_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fds_pkg::*;

    localparam int STAT_CAP     = SAMPLE_CAP_DEF;
    // well above the slowest correct run: the serial datapath of every sample
    // plus sender gaps and receiver stalls at 88 percent
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_SAMPLES = 2000;
    localparam int MAX_REPORTS  = 10;

    // how the two sides of the bus idle while an item is in flight
    typedef enum logic [1:0] {
        RECEIVER_SLOW,  // sender idles 22 percent, receiver 88 percent
        SENDER_SLOW,    // sender idles 88 percent, receiver 22 percent
        FULL_RATE       // neither side idles
    } traffic_phase_t;

    // one sample waiting to be driven
    typedef struct {
        logic [DUR_W-1:0] duration;
        traffic_phase_t   phase;
        logic             drain_first;  // hold off until every result is back
    } duration_item_t;

    // result fields, highest bits first, same layout as m_axis_tdata
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [DUR_W-1:0] minimum;
        logic [DUR_W-1:0] recent_average;
        logic [DUR_W-1:0] average;
    } duration_stats_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;   // [15:0] duration
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [15:0] average, [31:16] recent_average, [47:32] minimum, [55:48] count
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    duration_item_t   duration_queue[$];   // samples not yet driven
    duration_stats_t  expected_stats[$];   // predicted results, oldest first
    traffic_phase_t   traffic_phase = RECEIVER_SLOW;
    int unsigned      samples_accepted = 0;
    int unsigned      results_seen = 0;
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count = 0;

    // predictor state, reset values of the block
    logic [CNT_W-1:0] stat_count   = '0;
    logic [DUR_W-1:0] stat_average = '0;
    logic [DUR_W-1:0] stat_minimum = '1;
    logic [DUR_W-1:0] line_oldest  = '0;
    logic [DUR_W-1:0] line_middle  = '0;
    logic [DUR_W-1:0] line_newest  = '0;

    frame_duration_statistics #(
        .SAMPLE_CAP(STAT_CAP)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 aclk = ~aclk;

    // idle chance in percent for one side in a given phase
    function automatic int unsigned idle_percent(input traffic_phase_t phase,
                                                 input logic is_sender);
        case (phase)
            RECEIVER_SLOW: idle_percent = is_sender ? 22 : 88;
            SENDER_SLOW:   idle_percent = is_sender ? 88 : 22;
            default:       idle_percent = 0;
        endcase
    endfunction

    // running statistics after one more sample
    task automatic advance_statistics(input logic [DUR_W-1:0] duration,
                                      output duration_stats_t stats);
        logic [31:0] weighted_sum;
        logic [31:0] quotient;
        logic [17:0] window_sum;
        logic [17:0] window_mean;
        logic [DUR_W-1:0] recent;
        // average and count only move below the cap; count never passes 255
        if (stat_count < STAT_CAP && stat_count != '1) begin
            weighted_sum = stat_average * stat_count + duration;
            stat_count   = stat_count + 1'b1;
            quotient     = weighted_sum / stat_count;
            stat_average = quotient[DUR_W-1:0];
        end
        line_oldest = line_middle;
        line_middle = line_newest;
        line_newest = duration;
        // any zero in the window falls back to the current sample
        recent = duration;
        if (line_oldest != '0 && line_middle != '0 && line_newest != '0) begin
            window_sum  = line_oldest + line_middle + line_newest;
            window_mean = window_sum / DIV3;
            recent      = window_mean[DUR_W-1:0];
        end
        // a zero minimum gets replaced by whatever comes next
        if (stat_minimum == '0 || duration < stat_minimum)
            stat_minimum = duration;
        stats.average        = stat_average;
        stats.recent_average = recent;
        stats.minimum        = stat_minimum;
        stats.count          = stat_count;
    endtask

    task automatic add_sample(input logic [DUR_W-1:0] duration, input traffic_phase_t phase,
                              input logic drain_first);
        duration_item_t item;
        item.duration    = duration;
        item.phase       = phase;
        item.drain_first = drain_first;
        duration_queue.push_back(item);
    endtask

    // random sample biased toward zeros, the top of the range and small values
    function automatic logic [DUR_W-1:0] pick_duration(input logic [DUR_W-1:0] previous);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            pick_duration = '0;
        else if (roll < 16)
            pick_duration = DUR_W'($urandom_range(65000, 65535));
        else if (roll < 36)
            pick_duration = DUR_W'($urandom_range(1, 15));
        else if (roll < 50)
            pick_duration = previous + DUR_W'($urandom_range(0, 64)) - DUR_W'(32);
        else
            pick_duration = DUR_W'($urandom_range(0, 65535));
    endfunction

    // driver: one sample per transaction, tvalid held until accepted
    always @(posedge aclk) begin : drive_samples
        logic           next_valid;
        logic           hold_off;
        duration_item_t item;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                samples_accepted <= samples_accepted + 1;
                next_valid = 1'b0;
            end
            if (!next_valid && duration_queue.size() != 0) begin
                // a drain point waits until every sample so far has its result
                hold_off = duration_queue[0].drain_first &&
                           (samples_accepted != results_seen || s_axis_tvalid);
                if (!hold_off &&
                    $urandom_range(0, 99) >= idle_percent(duration_queue[0].phase, 1'b1)) begin
                    item = duration_queue.pop_front();
                    s_axis_tdata  <= IN_TDATA_W'(item.duration);
                    traffic_phase <= item.phase;
                    next_valid = 1'b1;
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // monitor: predicts on each input transaction, checks each result transaction
    always @(posedge aclk) begin : check_results
        duration_stats_t predicted;
        duration_stats_t seen;
        duration_stats_t wanted;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_statistics(s_axis_tdata[DUR_W-1:0], predicted);
                expected_stats.push_back(predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen = m_axis_tdata[$bits(duration_stats_t)-1:0];
                results_seen <= results_seen + 1;
                if (expected_stats.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("result %0d with no sample pending: %s%0d %0d %0d %0d",
                                 results_seen, "avg/recent/min/count = ",
                                 seen.average, seen.recent_average,
                                 seen.minimum, seen.count);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    wanted = expected_stats.pop_front();
                    if (seen.average !== wanted.average ||
                        seen.recent_average !== wanted.recent_average ||
                        seen.minimum !== wanted.minimum ||
                        seen.count !== wanted.count) begin
                        if (mismatch_count < MAX_REPORTS) begin
                            $display("result %0d: expected avg=%0d recent=%0d min=%0d count=%0d",
                                     results_seen, wanted.average, wanted.recent_average,
                                     wanted.minimum, wanted.count);
                            $display("result %0d: got avg=%0d recent=%0d min=%0d count=%0d",
                                     results_seen, seen.average, seen.recent_average,
                                     seen.minimum, seen.count);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= idle_percent(traffic_phase, 1'b0));
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [DUR_W-1:0] previous;
        traffic_phase_t   phase;

        // directed: top of range everywhere, zeros in the window and the minimum,
        // small values, alternating bit patterns
        add_sample(16'hFFFF, RECEIVER_SLOW, 1'b0);
        add_sample(16'hFFFF, RECEIVER_SLOW, 1'b0);
        add_sample(16'hFFFF, RECEIVER_SLOW, 1'b0);
        add_sample(16'hFFFE, RECEIVER_SLOW, 1'b0);
        add_sample(16'h0000, RECEIVER_SLOW, 1'b0);   // zero becomes the minimum
        add_sample(16'hC350, RECEIVER_SLOW, 1'b0);   // replaces a zero minimum
        add_sample(16'h0001, RECEIVER_SLOW, 1'b0);
        add_sample(16'h0002, RECEIVER_SLOW, 1'b0);
        add_sample(16'h0003, RECEIVER_SLOW, 1'b0);
        add_sample(16'h0000, RECEIVER_SLOW, 1'b1);
        add_sample(16'h0000, RECEIVER_SLOW, 1'b0);
        add_sample(16'h0007, RECEIVER_SLOW, 1'b0);
        add_sample(16'h0008, RECEIVER_SLOW, 1'b0);
        add_sample(16'h0009, RECEIVER_SLOW, 1'b0);   // window full of nonzero again
        add_sample(16'h5555, RECEIVER_SLOW, 1'b0);
        add_sample(16'hAAAA, RECEIVER_SLOW, 1'b0);
        add_sample(16'h8000, RECEIVER_SLOW, 1'b0);
        add_sample(16'h7FFF, RECEIVER_SLOW, 1'b0);
        add_sample(16'h0000, RECEIVER_SLOW, 1'b0);
        add_sample(16'hFFFF, RECEIVER_SLOW, 1'b0);

        // random part; the count freezes at the cap early on, so most of the
        // run checks the frozen average next to the moving window and minimum
        previous = 16'h1000;
        for (int i = 0; i < RANDOM_SAMPLES; i++) begin
            if (i < RANDOM_SAMPLES / 3)
                phase = RECEIVER_SLOW;
            else if (i < 2 * RANDOM_SAMPLES / 3)
                phase = SENDER_SLOW;
            else
                phase = FULL_RATE;
            previous = pick_duration(previous);
            add_sample(previous, phase,
                       i == RANDOM_SAMPLES / 3 || i == 2 * RANDOM_SAMPLES / 3 ||
                       $urandom_range(0, 99) == 0);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // all samples driven and accepted, then every result back
        while (duration_queue.size() != 0 || s_axis_tvalid)
            @(posedge aclk);
        while (samples_accepted != results_seen)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_stats.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
sv/fds_pkg.sv
sv/fds_serial_div.sv
sv/frame_duration_statistics.sv
sv/fds_checker.sv
tb/frame_duration_statistics_tb.sv
